// ===== src/sobel_hg_pkg.sv =====
package sobel_hg_pkg;

    localparam int PIX_W        = 8;
    localparam int CFG_W_W      = 11;
    localparam int CFG_H_W      = 16;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;
    localparam int MAX_WIDTH_DEF = 1024;

    localparam logic [CFG_W_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [CFG_H_W-1:0] FRAME_HEIGHT_RST = 16'd480;

    // Register indexes, taken from paddr[2].
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    typedef logic [PIX_W-1:0] pixel_t;

endpackage

// ===== src/sobel_hg_in_if.sv =====
interface sobel_hg_in_if;
    import sobel_hg_pkg::*;

    logic   valid;
    logic   ready;
    logic   mode;
    pixel_t pixel;

    modport source (output valid, output mode, output pixel, input ready);
    modport sink (input valid, input mode, input pixel, output ready);
endinterface

// ===== src/sobel_hg_out_if.sv =====
interface sobel_hg_out_if;
    import sobel_hg_pkg::*;

    logic   valid;
    logic   ready;
    pixel_t gradient;
    logic   frame_end;

    modport source (output valid, output gradient, output frame_end, input ready);
    modport sink (input valid, input gradient, input frame_end, output ready);
endinterface

// ===== src/sobel_horizontal_gradient_filter.sv =====
// Streaming 3x3 horizontal Sobel gradient filter for 8-bit grayscale frames.
//
// Input channel pix carries one beat per pixel in raster order (mode = 0), or
// a drain tick (mode = 1). Output channel grad carries one beat per filtered
// pixel in raster order; frame_end marks the last beat of a frame. Output
// beats lag the input by one row plus one pixel (W+1 beats, W = effective
// width), so after the last pixel of a frame W+1 drain ticks flush the rest.
// Drain ticks inside a frame are taken and dropped; pixels beyond the end of
// the frame act as drain ticks.
//
// Throughput is one beat per cycle while grad does not stall; the single line
// memory (one read and one write port, holding both earlier rows side by side)
// sets that figure. A result passes the memory stage register and then the
// output register before it goes valid on grad. If grad stalls with a beat
// waiting, the output register holds it and pix.ready drops in the same cycle
// whenever the memory stage also holds a beat; no beat is lost.
//
// Reset clears the counters, the 3x3 window and the pipeline valids and loads
// a 640 x 480 frame size. The line memory is not cleared: entries are always
// written before border replication lets them reach a result.
// frame_width and frame_height are written over APB at byte addresses 0 and 4.
module sobel_horizontal_gradient_filter #(
    parameter int MAX_WIDTH = sobel_hg_pkg::MAX_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sobel_hg_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [sobel_hg_pkg::APB_DATA_W-1:0] pwdata,
    output logic [sobel_hg_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    sobel_hg_in_if.sink                         pix,
    sobel_hg_out_if.source                      grad
);
    import sobel_hg_pkg::*;

    localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W  = (WCNT_W > CFG_W_W) ? WCNT_W : CFG_W_W;
    localparam int ROW_W  = CFG_H_W + 1;
    localparam int SUM_W  = PIX_W + 3;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [CFG_W_W-1:0] frame_width_reg;
    logic [CFG_H_W-1:0] frame_height_reg;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[CFG_W_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[CFG_H_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height_reg);
            default:          prdata = '0;
        endcase
    end

    // Effective sizes: a zero size acts as one, the width is capped by the
    // line memory depth.
    logic [CMP_W-1:0]   eff_w;
    logic [CFG_H_W-1:0] eff_h;
    logic [CMP_W-1:0]   fw_cmp;

    assign fw_cmp = CMP_W'(frame_width_reg);
    assign eff_h  = (frame_height_reg == '0) ? CFG_H_W'(1) : frame_height_reg;

    always_comb
    begin
        if (fw_cmp == '0)
            eff_w = CMP_W'(1);
        else if (fw_cmp > CMP_W'(MAX_WIDTH))
            eff_w = CMP_W'(MAX_WIDTH);
        else
            eff_w = fw_cmp;
    end

    // ------------------------------------------------------------------
    // Accept stage: all position bookkeeping is done here, so that the
    // next beat sees up-to-date counters in the following cycle.
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0]  in_col_reg, in_col_next;
    logic [ROW_W-1:0]   in_row_reg, in_row_next;
    logic [ADDR_W-1:0]  out_col_reg, out_col_next;
    logic [CFG_H_W-1:0] out_row_reg, out_row_next;

    logic               in_fire;
    logic               in_wrap;
    logic [ADDR_W-1:0]  cur_col;
    logic [ROW_W-1:0]   cur_row;
    logic               beyond_frame;
    logic               drop_beat;
    logic               take_beat;
    logic               emit;
    logic               last;
    logic [CMP_W-1:0]   in_col_plus;
    logic [CMP_W-1:0]   out_col_plus;
    logic [ROW_W-1:0]   out_row_plus;

    // Memory stage registers.
    logic               b_valid_reg;
    logic [ADDR_W-1:0]  b_addr_reg;
    logic               b_drain_reg;
    pixel_t             b_px_reg;
    logic               b_emit_reg;
    logic               b_first_col_reg;
    logic               b_left_edge_reg;
    logic               b_top_reg;
    logic               b_last_reg;
    logic               b_ready;
    logic               b_fire;

    // Output register.
    logic               out_valid_reg;
    pixel_t             gradient_reg;
    logic               frame_end_reg;

    assign b_ready   = !out_valid_reg || grad.ready;
    assign b_fire    = b_valid_reg && b_ready;
    assign pix.ready = !b_valid_reg || b_ready;
    assign in_fire   = pix.valid && pix.ready;

    // A width lowered part way through a row leaves the column at or past the
    // new width; such a column starts the next row before the beat is used.
    assign in_wrap = CMP_W'(in_col_reg) >= eff_w;
    assign cur_col = in_wrap ? '0 : in_col_reg;
    assign cur_row = (in_wrap && (in_row_reg != '1)) ? in_row_reg + ROW_W'(1) : in_row_reg;

    assign beyond_frame = cur_row >= ROW_W'(eff_h);
    assign drop_beat    = !beyond_frame && (pix.mode == MODE_DRAIN);
    assign take_beat    = in_fire && !drop_beat;
    assign emit         = (cur_row >= ROW_W'(2))
                       || ((cur_row == ROW_W'(1)) && (cur_col != '0));
    assign in_col_plus  = CMP_W'(cur_col) + CMP_W'(1);
    assign out_col_plus = CMP_W'(out_col_reg) + CMP_W'(1);
    assign out_row_plus = ROW_W'(out_row_reg) + ROW_W'(1);
    assign last         = (out_row_plus >= ROW_W'(eff_h)) && (out_col_plus >= eff_w);

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        // Any accepted beat, even a dropped drain tick, keeps the row wrap.
        if (in_fire)
        begin
            in_col_next = cur_col;
            in_row_next = cur_row;
        end
        if (take_beat)
        begin
            if (in_col_plus >= eff_w)
            begin
                in_col_next = '0;
                // The row counter saturates rather than wrapping.
                if (cur_row != '1)
                    in_row_next = cur_row + ROW_W'(1);
            end
            else
            begin
                in_col_next = ADDR_W'(in_col_plus);
            end
            if (emit)
            begin
                if (out_col_plus >= eff_w)
                begin
                    out_col_next = '0;
                    out_row_next = CFG_H_W'(out_row_plus);
                end
                else
                begin
                    out_col_next = ADDR_W'(out_col_plus);
                end
                if (last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // ------------------------------------------------------------------
    // Line memory: each entry holds {older row, recent row} for one column.
    // It is read when a beat is taken and written back when that beat
    // leaves the memory stage.
    // ------------------------------------------------------------------
    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_data_reg;
    logic               fwd_reg;
    logic [2*PIX_W-1:0] fwd_data_reg;
    pixel_t             cur_older;
    pixel_t             cur_recent;
    pixel_t             cur_px;
    logic [2*PIX_W-1:0] wr_data;

    // With a one-pixel row the next beat reads the column that is being
    // written back in the same cycle; that write is forwarded instead.
    assign cur_older  = fwd_reg ? fwd_data_reg[2*PIX_W-1:PIX_W] : rd_data_reg[2*PIX_W-1:PIX_W];
    assign cur_recent = fwd_reg ? fwd_data_reg[PIX_W-1:0] : rd_data_reg[PIX_W-1:0];
    // Past the last row the bottom row is replicated.
    assign cur_px     = b_drain_reg ? cur_recent : b_px_reg;
    assign wr_data    = {cur_recent, cur_px};

    always_ff @(posedge clk)
    begin
        if (b_fire)
            line_mem[b_addr_reg] <= wr_data;
        if (take_beat)
            rd_data_reg <= line_mem[cur_col];
    end

    always_ff @(posedge clk)
    begin
        if (take_beat)
        begin
            fwd_data_reg    <= wr_data;
            b_addr_reg      <= cur_col;
            b_drain_reg     <= beyond_frame;
            b_px_reg        <= pix.pixel;
            b_first_col_reg <= (cur_col == '0);
            b_left_edge_reg <= (out_col_reg == '0);
            b_top_reg       <= (out_row_reg == '0);
            b_last_reg      <= emit && last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            b_emit_reg  <= 1'b0;
            fwd_reg     <= 1'b0;
        end
        else
        begin
            if (take_beat)
            begin
                b_valid_reg <= 1'b1;
                b_emit_reg  <= emit;
                fwd_reg     <= b_valid_reg && (b_addr_reg == cur_col);
            end
            else if (b_fire)
            begin
                b_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // 3x3 window, indexed [column left..right][row top..bottom], and the
    // gradient. On the first column of a row the result belongs to the
    // last column of the previous row and uses the window before the shift.
    // ------------------------------------------------------------------
    pixel_t                  win_reg [3][3];
    pixel_t                  left_px [3];
    pixel_t                  right_px [3];
    logic signed [SUM_W-1:0] diff [3];
    logic signed [SUM_W-1:0] sum;
    pixel_t                  grad_val;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            if (b_first_col_reg)
            begin
                right_px[r] = win_reg[2][r];
                left_px[r]  = b_left_edge_reg ? win_reg[2][r] : win_reg[1][r];
            end
            else
            begin
                left_px[r] = b_left_edge_reg ? win_reg[2][r] : win_reg[1][r];
                case (r)
                    0:       right_px[r] = cur_older;
                    1:       right_px[r] = cur_recent;
                    default: right_px[r] = cur_px;
                endcase
            end
        end
        // Top border: the missing row above is the middle row.
        if (b_top_reg)
        begin
            left_px[0]  = left_px[1];
            right_px[0] = right_px[1];
        end
        for (int r = 0; r < 3; r++)
            diff[r] = $signed({3'b000, right_px[r]}) - $signed({3'b000, left_px[r]});
        sum = diff[0] + (diff[1] <<< 1) + diff[2];
        if (sum[SUM_W-1])
            grad_val = '0;
        else if (sum > SUM_W'(255))
            grad_val = '1;
        else
            grad_val = sum[PIX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < 3; c++)
                for (int r = 0; r < 3; r++)
                    win_reg[c][r] <= '0;
        end
        else if (b_fire)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[0][r] <= win_reg[1][r];
                win_reg[1][r] <= win_reg[2][r];
            end
            win_reg[2][0] <= cur_older;
            win_reg[2][1] <= cur_recent;
            win_reg[2][2] <= cur_px;
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (b_fire && b_emit_reg)
            out_valid_reg <= 1'b1;
        else if (grad.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (b_fire && b_emit_reg)
        begin
            gradient_reg  <= grad_val;
            frame_end_reg <= b_last_reg;
        end
    end

    assign grad.valid     = out_valid_reg;
    assign grad.gradient  = gradient_reg;
    assign grad.frame_end = frame_end_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_fwd_only_single_column: assert property (
        @(posedge clk) disable iff (!rst_n)
        (b_valid_reg && fwd_reg) |-> (b_addr_reg == '0)
    ) else $error("forwarding used on a column other than zero");

    a_last_needs_emit: assert property (
        @(posedge clk) disable iff (!rst_n)
        (b_valid_reg && b_last_reg) |-> b_emit_reg
    ) else $error("frame end flagged on a beat without a result");

    a_result_reaches_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        (b_fire && b_emit_reg) |=> (out_valid_reg && (frame_end_reg == $past(b_last_reg)))
    ) else $error("result from the memory stage did not reach the output register");

endmodule
